// ----- sv/gradient_noise_lattice_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gradient noise lattice checker
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_LATTICE_MACROS_SVH
`define GRADIENT_NOISE_LATTICE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define GNL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gradient noise lattice: property failed");

// The consequent must hold in the same cycle as the antecedent.
`define GNL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gradient noise lattice: property failed");

`endif

// ----- sv/gnl_pkg.sv -----
// ----------------------------------------------------------------------------
// gnl_pkg
// Shared widths, command codes and the queued item type of the noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnl_pkg;

  localparam int TBL_DEPTH = 256;
  localparam int CELL_W    = 8;
  localparam int FRAC_W    = 16;
  localparam int COORD_W   = 29;
  localparam int GRAD_W    = 15;
  localparam int GRAD_FRAC = 14;
  localparam int OUT_W     = 19;
  localparam int PROD_W    = FRAC_W + 1 + GRAD_W;
  localparam int DOT_W     = 19;
  localparam int DIFF_W    = DOT_W + 1;
  localparam int LPROD_W   = FRAC_W + 2 + DIFF_W;

  typedef enum logic [1:0] {
    CMD_EVAL      = 2'd0,
    CMD_LOAD_PERM = 2'd1,
    CMD_LOAD_G3   = 2'd2,
    CMD_LOAD_G2   = 2'd3
  } cmd_e;

  localparam logic [1:0] DIMS_1 = 2'd1;
  localparam logic [1:0] DIMS_2 = 2'd2;
  localparam logic [1:0] DIMS_3 = 2'd3;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    cmd_e                     cmd;
    logic [1:0]               dims;
    logic [CELL_W-1:0]        bx0;
    logic [CELL_W-1:0]        bx1;
    logic [CELL_W-1:0]        by0;
    logic [CELL_W-1:0]        by1;
    logic [CELL_W-1:0]        bz0;
    logic [CELL_W-1:0]        bz1;
    logic [FRAC_W-1:0]        fx;
    logic [FRAC_W-1:0]        fy;
    logic [FRAC_W-1:0]        fz;
    logic [CELL_W-1:0]        idx;
    logic [CELL_W-1:0]        perm;
    logic signed [GRAD_W-1:0] ga;
    logic signed [GRAD_W-1:0] gb;
    logic signed [GRAD_W-1:0] gc;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/gnl_ram.sv -----
// ----------------------------------------------------------------------------
// gnl_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module gnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr0_i,
  input  wire logic [AW-1:0]    raddr1_i,
  output logic      [WIDTH-1:0] rdata0_o,
  output logic      [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd0_q;
  logic [WIDTH-1:0] rd1_q;

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rd0_q <= mem_q[raddr0_i];
      rd1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

`default_nettype wire

// ----- sv/gnl_front.sv -----
// ----------------------------------------------------------------------------
// gnl_front
// Classifies an incoming beat and splits coordinates into cell and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module gnl_front (
  input  wire logic        [1:0]                   cmd_i,
  input  wire logic        [1:0]                   dims_i,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]  coord_x_i,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]  coord_y_i,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]  coord_z_i,
  input  wire logic        [gnl_pkg::CELL_W-1:0]   entry_index_i,
  input  wire logic        [gnl_pkg::CELL_W-1:0]   perm_value_i,
  input  wire logic signed [gnl_pkg::GRAD_W-1:0]   grad_a_i,
  input  wire logic signed [gnl_pkg::GRAD_W-1:0]   grad_b_i,
  input  wire logic signed [gnl_pkg::GRAD_W-1:0]   grad_c_i,
  output gnl_pkg::item_t                           item_o
);

  localparam int FW = gnl_pkg::FRAC_W;
  localparam int CW = gnl_pkg::CELL_W;

  // The cell is the floored coordinate masked to the table size.
  always_comb begin
    item_o      = '0;
    item_o.cmd  = gnl_pkg::cmd_e'(cmd_i);
    item_o.dims = dims_i;
    item_o.bx0  = coord_x_i[FW +: CW];
    item_o.by0  = coord_y_i[FW +: CW];
    item_o.bz0  = coord_z_i[FW +: CW];
    item_o.bx1  = CW'(coord_x_i[FW +: CW] + 1'b1);
    item_o.by1  = CW'(coord_y_i[FW +: CW] + 1'b1);
    item_o.bz1  = CW'(coord_z_i[FW +: CW] + 1'b1);
    item_o.fx   = coord_x_i[FW-1:0];
    item_o.fy   = coord_y_i[FW-1:0];
    item_o.fz   = coord_z_i[FW-1:0];
    item_o.idx  = entry_index_i;
    item_o.perm = perm_value_i;
    item_o.ga   = grad_a_i;
    item_o.gb   = grad_b_i;
    item_o.gc   = grad_c_i;
  end

endmodule

`default_nettype wire

// ----- sv/gnl_queue.sv -----
// ----------------------------------------------------------------------------
// gnl_queue
// Two-entry queue that decouples the front from the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gnl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire gnl_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output gnl_pkg::item_t      item_o
);

  gnl_pkg::item_t mem_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gnl_back.sv -----
// ----------------------------------------------------------------------------
// gnl_back
// Lock-step pipeline: hashing, gradient lookup, dot products and blending.
// ----------------------------------------------------------------------------
`default_nettype none

module gnl_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire gnl_pkg::item_t                q_item_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [gnl_pkg::OUT_W-1:0]   noise_value_o
);

  localparam int FW  = gnl_pkg::FRAC_W;
  localparam int CW  = gnl_pkg::CELL_W;
  localparam int GW  = gnl_pkg::GRAD_W;
  localparam int PW  = gnl_pkg::PROD_W;
  localparam int DW  = gnl_pkg::DOT_W;
  localparam int FDW = gnl_pkg::DIFF_W;
  localparam int LW  = gnl_pkg::LPROD_W;
  localparam int NS  = 11;
  localparam logic [FW+1:0] THREE_Q = (FW + 2)'(3) << FW;

  typedef struct packed {
    logic                   v;
    logic                   ev;
    gnl_pkg::cmd_e          cmd;
    logic [1:0]             dims;
    logic [CW-1:0]          bx0;
    logic [CW-1:0]          bx1;
    logic [CW-1:0]          by0;
    logic [CW-1:0]          by1;
    logic [CW-1:0]          bz0;
    logic [CW-1:0]          bz1;
    logic [FW-1:0]          fx;
    logic [FW-1:0]          fy;
    logic [FW-1:0]          fz;
    logic [FW-1:0]          tx;
    logic [FW-1:0]          ty;
    logic [FW-1:0]          tz;
    logic [FW:0]            sx;
    logic [FW:0]            sy;
    logic [FW:0]            sz;
    logic [CW-1:0]          idx;
    logic [CW-1:0]          perm;
    logic [GW-1:0]          ga;
    logic [GW-1:0]          gb;
    logic [GW-1:0]          gc;
    logic [GW-1:0]          g1a;
    logic [GW-1:0]          g1b;
    logic [7:0][2:0][PW-1:0] prd;
    logic [7:0][DW-1:0]     dot;
    logic [3:0][LW-1:0]     lp;
    logic [3:0][DW-1:0]     la;
    logic [3:0][DW-1:0]     lv;
    logic [DW-1:0]          res1;
    logic [DW-1:0]          res2;
  } pipe_t;

  pipe_t              p_q [1:NS];
  pipe_t              p_d [1:NS];
  logic               en;
  logic               out_valid_q;
  logic [DW-1:0]      out_value_q;
  logic [DW-1:0]      out_value_d;
  logic [DW-1:0]      fin;

  logic [CW-1:0]      pa_rd0, pa_rd1, pb_rd0, pb_rd1, pc_rd0, pc_rd1;
  logic [GW-1:0]      g1_rd0, g1_rd1;
  logic [2*GW-1:0]    g2_rd [4];
  logic [3*GW-1:0]    g3_rd [8];
  logic [CW-1:0]      ha0, ha1, hb0, hb1, hc0, hc1;

  // Upper half of t*t.
  function automatic logic [FW-1:0] sq_hi(input logic [FW-1:0] t);
    logic [2*FW-1:0] p;
    p = t * t;
    return p[2*FW-1:FW];
  endfunction

  // Smoothstep: t2 * (3 - 2t), scaled back to the fraction format.
  function automatic logic [FW:0] s_fin(input logic [FW-1:0] t2, input logic [FW-1:0] t);
    logic [FW+1:0]   f;
    logic [2*FW+1:0] p;
    f = THREE_Q - {1'b0, t, 1'b0};
    p = t2 * f;
    return p[FW +: FW+1];
  endfunction

  function automatic logic [PW-1:0] mulg(input logic signed [FW:0] r,
                                         input logic signed [GW-1:0] g);
    logic signed [PW-1:0] p;
    p = r * g;
    return p;
  endfunction

  // Sum of three products, floored to the fraction format.
  function automatic logic [DW-1:0] dsum(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                         input logic [PW-1:0] c);
    logic signed [PW:0] s;
    s = $signed({a[PW-1], a}) + $signed({b[PW-1], b}) + $signed({c[PW-1], c});
    return s[gnl_pkg::GRAD_FRAC +: DW];
  endfunction

  // Weight times the difference of the two end points.
  function automatic logic [LW-1:0] lmul(input logic [FW:0] s, input logic [DW-1:0] a,
                                         input logic [DW-1:0] b);
    logic signed [FDW-1:0] d;
    logic signed [LW-1:0]  p;
    d = $signed({b[DW-1], b}) - $signed({a[DW-1], a});
    p = $signed({1'b0, s}) * d;
    return p;
  endfunction

  function automatic logic [DW-1:0] lsum(input logic [DW-1:0] a, input logic [LW-1:0] p);
    logic signed [FDW-1:0] t;
    t = $signed({a[DW-1], a}) + $signed(p[FW +: FDW]);
    return t[DW-1:0];
  endfunction

  // The whole pipeline moves unless a finished result is held back.
  assign en          = !(out_valid_q && out_stall_i);
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign noise_value_o = $signed(out_value_q);

  // First hash level: permutation of the x cells.
  gnl_ram #(.WIDTH(CW), .DEPTH(gnl_pkg::TBL_DEPTH)) u_perm_a (
    .clk_i, .en_i(en),
    .we_i(en && p_q[1].v && p_q[1].cmd == gnl_pkg::CMD_LOAD_PERM),
    .waddr_i(p_q[1].idx), .wdata_i(p_q[1].perm),
    .raddr0_i(p_q[1].bx0), .raddr1_i(p_q[1].bx1),
    .rdata0_o(pa_rd0), .rdata1_o(pa_rd1)
  );

  // Second hash level: two copies for the four y corners.
  always_comb begin
    ha0 = CW'(pa_rd0 + p_q[2].by0);
    ha1 = CW'(pa_rd1 + p_q[2].by0);
    hb0 = CW'(pa_rd0 + p_q[2].by1);
    hb1 = CW'(pa_rd1 + p_q[2].by1);
  end

  gnl_ram #(.WIDTH(CW), .DEPTH(gnl_pkg::TBL_DEPTH)) u_perm_b (
    .clk_i, .en_i(en),
    .we_i(en && p_q[2].v && p_q[2].cmd == gnl_pkg::CMD_LOAD_PERM),
    .waddr_i(p_q[2].idx), .wdata_i(p_q[2].perm),
    .raddr0_i(ha0), .raddr1_i(ha1),
    .rdata0_o(pb_rd0), .rdata1_o(pb_rd1)
  );

  gnl_ram #(.WIDTH(CW), .DEPTH(gnl_pkg::TBL_DEPTH)) u_perm_c (
    .clk_i, .en_i(en),
    .we_i(en && p_q[2].v && p_q[2].cmd == gnl_pkg::CMD_LOAD_PERM),
    .waddr_i(p_q[2].idx), .wdata_i(p_q[2].perm),
    .raddr0_i(hb0), .raddr1_i(hb1),
    .rdata0_o(pc_rd0), .rdata1_o(pc_rd1)
  );

  // One-dimensional gradients, looked up next to the second hash level.
  gnl_ram #(.WIDTH(GW), .DEPTH(gnl_pkg::TBL_DEPTH)) u_grad1 (
    .clk_i, .en_i(en),
    .we_i(en && p_q[2].v && p_q[2].cmd == gnl_pkg::CMD_LOAD_PERM),
    .waddr_i(p_q[2].idx), .wdata_i(p_q[2].ga),
    .raddr0_i(pa_rd0), .raddr1_i(pa_rd1),
    .rdata0_o(g1_rd0), .rdata1_o(g1_rd1)
  );

  // Two- and three-dimensional gradient copies, one pair of corners each.
  always_comb begin
    hc0 = pb_rd0;
    hc1 = pb_rd1;
  end

  for (genvar k = 0; k < 2; k++) begin : g_grad2
    gnl_ram #(.WIDTH(2*GW), .DEPTH(gnl_pkg::TBL_DEPTH)) u_grad2 (
      .clk_i, .en_i(en),
      .we_i(en && p_q[3].v && p_q[3].cmd == gnl_pkg::CMD_LOAD_G2),
      .waddr_i(p_q[3].idx), .wdata_i({p_q[3].gb, p_q[3].ga}),
      .raddr0_i((k == 1) ? pc_rd0 : hc0), .raddr1_i((k == 1) ? pc_rd1 : hc1),
      .rdata0_o(g2_rd[2*k]), .rdata1_o(g2_rd[2*k+1])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_grad3
    logic [CW-1:0] a0, a1, zc;
    assign zc = (k >= 2) ? p_q[3].bz1 : p_q[3].bz0;
    assign a0 = CW'(((k % 2) == 1 ? pc_rd0 : pb_rd0) + zc);
    assign a1 = CW'(((k % 2) == 1 ? pc_rd1 : pb_rd1) + zc);
    gnl_ram #(.WIDTH(3*GW), .DEPTH(gnl_pkg::TBL_DEPTH)) u_grad3 (
      .clk_i, .en_i(en),
      .we_i(en && p_q[3].v && p_q[3].cmd == gnl_pkg::CMD_LOAD_G3),
      .waddr_i(p_q[3].idx), .wdata_i({p_q[3].gc, p_q[3].gb, p_q[3].ga}),
      .raddr0_i(a0), .raddr1_i(a1),
      .rdata0_o(g3_rd[2*k]), .rdata1_o(g3_rd[2*k+1])
    );
  end

  // Stage arithmetic.
  always_comb begin
    logic signed [FW:0]   rx, ry, rz;
    logic signed [GW-1:0] gx, gy, gz;

    // Entry from the queue.
    p_d[1]      = '0;
    p_d[1].v    = q_valid_i;
    p_d[1].ev   = (q_item_i.cmd == gnl_pkg::CMD_EVAL);
    p_d[1].cmd  = q_item_i.cmd;
    p_d[1].dims = q_item_i.dims;
    p_d[1].bx0  = q_item_i.bx0;
    p_d[1].bx1  = q_item_i.bx1;
    p_d[1].by0  = q_item_i.by0;
    p_d[1].by1  = q_item_i.by1;
    p_d[1].bz0  = q_item_i.bz0;
    p_d[1].bz1  = q_item_i.bz1;
    p_d[1].fx   = q_item_i.fx;
    p_d[1].fy   = q_item_i.fy;
    p_d[1].fz   = q_item_i.fz;
    p_d[1].idx  = q_item_i.idx;
    p_d[1].perm = q_item_i.perm;
    p_d[1].ga   = q_item_i.ga;
    p_d[1].gb   = q_item_i.gb;
    p_d[1].gc   = q_item_i.gc;

    // Fade curve, first half: squares of the fractions.
    p_d[2]    = p_q[1];
    p_d[2].tx = sq_hi(p_q[1].fx);
    p_d[2].ty = sq_hi(p_q[1].fy);
    p_d[2].tz = sq_hi(p_q[1].fz);

    // Fade curve, second half.
    p_d[3]    = p_q[2];
    p_d[3].sx = s_fin(p_q[2].tx, p_q[2].fx);
    p_d[3].sy = s_fin(p_q[2].ty, p_q[2].fy);
    p_d[3].sz = s_fin(p_q[2].tz, p_q[2].fz);

    // Keep the 1-D gradients until the other lookups arrive.
    p_d[4]     = p_q[3];
    p_d[4].g1a = g1_rd0;
    p_d[4].g1b = g1_rd1;

    // Corner gradients times corner offsets; bit 0 of a corner is x.
    p_d[5] = p_q[4];
    for (int c = 0; c < 8; c++) begin
      rx = $signed({((c & 1) != 0), p_q[4].fx});
      ry = $signed({((c & 2) != 0), p_q[4].fy});
      rz = $signed({((c & 4) != 0), p_q[4].fz});
      gx = '0;
      gy = '0;
      gz = '0;
      unique case (p_q[4].dims)
        gnl_pkg::DIMS_3: begin
          gx = $signed(g3_rd[c][GW-1:0]);
          gy = $signed(g3_rd[c][2*GW-1:GW]);
          gz = $signed(g3_rd[c][3*GW-1:2*GW]);
        end
        gnl_pkg::DIMS_2: begin
          if (c < 4) begin
            gx = $signed(g2_rd[c % 4][GW-1:0]);
            gy = $signed(g2_rd[c % 4][2*GW-1:GW]);
          end
        end
        gnl_pkg::DIMS_1: begin
          if (c == 0) gx = $signed(p_q[4].g1a);
          if (c == 1) gx = $signed(p_q[4].g1b);
        end
        default: begin
          gx = '0;
        end
      endcase
      p_d[5].prd[c][0] = mulg(rx, gx);
      p_d[5].prd[c][1] = mulg(ry, gy);
      p_d[5].prd[c][2] = mulg(rz, gz);
    end

    // Dot products.
    p_d[6] = p_q[5];
    for (int c = 0; c < 8; c++) begin
      p_d[6].dot[c] = dsum(p_q[5].prd[c][0], p_q[5].prd[c][1], p_q[5].prd[c][2]);
    end

    // Blend along x.
    p_d[7] = p_q[6];
    for (int k = 0; k < 4; k++) begin
      p_d[7].lp[k] = lmul(p_q[6].sx, p_q[6].dot[2*k], p_q[6].dot[2*k+1]);
      p_d[7].la[k] = p_q[6].dot[2*k];
    end

    p_d[8] = p_q[7];
    for (int k = 0; k < 4; k++) begin
      p_d[8].lv[k] = lsum(p_q[7].la[k], p_q[7].lp[k]);
    end

    // Blend along y.
    p_d[9]       = p_q[8];
    p_d[9].res1  = p_q[8].lv[0];
    p_d[9].lp[0] = lmul(p_q[8].sy, p_q[8].lv[0], p_q[8].lv[1]);
    p_d[9].la[0] = p_q[8].lv[0];
    p_d[9].lp[1] = lmul(p_q[8].sy, p_q[8].lv[2], p_q[8].lv[3]);
    p_d[9].la[1] = p_q[8].lv[2];

    p_d[10]       = p_q[9];
    p_d[10].lv[0] = lsum(p_q[9].la[0], p_q[9].lp[0]);
    p_d[10].lv[1] = lsum(p_q[9].la[1], p_q[9].lp[1]);

    // Blend along z.
    p_d[11]       = p_q[10];
    p_d[11].res2  = p_q[10].lv[0];
    p_d[11].lp[0] = lmul(p_q[10].sz, p_q[10].lv[0], p_q[10].lv[1]);
    p_d[11].la[0] = p_q[10].lv[0];
  end

  // Final sum and selection by dimension; the Q2.16 range always holds it.
  always_comb begin
    fin = lsum(p_q[NS].la[0], p_q[NS].lp[0]);
    unique case (p_q[NS].dims)
      gnl_pkg::DIMS_1: out_value_d = p_q[NS].res1;
      gnl_pkg::DIMS_2: out_value_d = p_q[NS].res2;
      gnl_pkg::DIMS_3: out_value_d = fin;
      default:         out_value_d = '0;
    endcase
  end

  // Pipeline registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= NS; s++) begin
        p_q[s] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      for (int s = 1; s <= NS; s++) begin
        p_q[s] <= p_d[s];
      end
      out_valid_q <= p_q[NS].v && p_q[NS].ev;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_value_q <= out_value_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/gradient_noise_lattice.sv -----
// Throughput: one beat per cycle while no result is held back; table loads and evaluates may interleave.
// The rate is set by the eleven-stage back pipeline and replicated table RAMs.
// Reset clears the queue and pipeline valid state; tables keep no reset value.
// ----------------------------------------------------------------------------
// gradient_noise_lattice
// Fixed-point lattice gradient noise in one, two or three dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_lattice (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic        [1:0]                   cmd_i,
  input  wire logic        [1:0]                   dims_i,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]  coord_x_i,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]  coord_y_i,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]  coord_z_i,
  input  wire logic        [gnl_pkg::CELL_W-1:0]   entry_index_i,
  input  wire logic        [gnl_pkg::CELL_W-1:0]   perm_value_i,
  input  wire logic signed [gnl_pkg::GRAD_W-1:0]   grad_a_i,
  input  wire logic signed [gnl_pkg::GRAD_W-1:0]   grad_b_i,
  input  wire logic signed [gnl_pkg::GRAD_W-1:0]   grad_c_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [gnl_pkg::OUT_W-1:0]         noise_value_o
);

  gnl_pkg::item_t front_item;
  gnl_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  // Classify and split the incoming beat.
  gnl_front u_front (
    .cmd_i, .dims_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .entry_index_i, .perm_value_i, .grad_a_i, .grad_b_i, .grad_c_i,
    .item_o(front_item)
  );

  // Queue between the front and the back.
  gnl_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i), .item_i(front_item), .full_o(in_stall_o),
    .pop_i(q_pop), .valid_o(q_valid), .item_o(q_item)
  );

  // Table lookups and arithmetic.
  gnl_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .noise_value_o
  );

endmodule

`default_nettype wire

// ----- sv/gnl_checker.sv -----
// ----------------------------------------------------------------------------
// gnl_checker
// Port-level checks of the noise block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gradient_noise_lattice_macros.svh"

module gnl_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [gnl_pkg::OUT_W-1:0]  noise_value_o
);

  // A held result beat stays offered.
  `GNL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // A held result beat keeps its value.
  `GNL_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(noise_value_o))

  // When the output was not held last cycle the queue cannot be full, so input is open.
  `GNL_ASSERT_NOW(a_queue_drains, $past(!(out_valid_o && out_stall_i)), !in_stall_o)

  // Input stall only builds while the output is held back.
  `GNL_ASSERT_NEXT(a_stall_cause, in_valid_i && in_stall_o, $past(out_valid_o))

endmodule

bind gradient_noise_lattice gnl_checker u_gnl_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for gradient_noise_lattice
// Loads every table entry, then drives a short table of directed beats and
// several hundred random beats under varying back-pressure. Each evaluate
// result is checked in order against a predictor of the noise arithmetic or a value given with its row.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 1500;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 30;
  localparam int RANDOM_BEATS   = 510;
  localparam int DEPTH          = gnl_pkg::TBL_DEPTH;
  localparam int FW             = gnl_pkg::FRAC_W;
  localparam int GF             = gnl_pkg::GRAD_FRAC;
  localparam int OW             = gnl_pkg::OUT_W;
  localparam int XW             = gnl_pkg::COORD_W;
  localparam int EW             = gnl_pkg::CELL_W;
  localparam int GW             = gnl_pkg::GRAD_W;
  localparam logic signed [GW-1:0] GRAD_MIN = 15'sh4000;
  localparam logic signed [GW-1:0] GRAD_MAX = 15'sh3fff;

  typedef struct {
    gnl_pkg::cmd_e            cmd;
    logic [1:0]               dims;
    logic signed [XW-1:0]     x;
    logic signed [XW-1:0]     y;
    logic signed [XW-1:0]     z;
    logic [EW-1:0]            idx;
    logic [EW-1:0]            perm;
    logic signed [GW-1:0]     ga;
    logic signed [GW-1:0]     gb;
    logic signed [GW-1:0]     gc;
  } beat_t;

  typedef struct {
    beat_t             b;
    bit                typed;
    logic [OW-1:0]     value;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic [1:0] dims_i = '0;
  logic signed [XW-1:0] coord_x_i = '0;
  logic signed [XW-1:0] coord_y_i = '0;
  logic signed [XW-1:0] coord_z_i = '0;
  logic [EW-1:0] entry_index_i = '0;
  logic [EW-1:0] perm_value_i = '0;
  logic signed [GW-1:0] grad_a_i = '0;
  logic signed [GW-1:0] grad_b_i = '0;
  logic signed [GW-1:0] grad_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OW-1:0] noise_value_o;

  // Shadow copies of the lattice tables.
  int perm_mem [DEPTH];
  int grad1_mem [DEPTH];
  int grad2_mem [DEPTH][2];
  int grad3_mem [DEPTH][3];

  logic [OW-1:0] noise_expected [$];
  row_t directed_rows [$];
  int mismatches = 0;
  int failures = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_count = 0;
  int idle_cycles = 0;

  gradient_noise_lattice uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .dims_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .entry_index_i, .perm_value_i,
    .grad_a_i, .grad_b_i, .grad_c_i, .out_valid_o, .out_stall_i, .noise_value_o
  );

  always #4 clk_i = ~clk_i;

  // Smoothstep weight t*t*(3-2t) in Q.16.
  function automatic longint fade(longint t);
    longint t2;
    t2 = (t * t) >> FW;
    return (t2 * (3 * (longint'(1) << FW) - 2 * t)) >> FW;
  endfunction

  function automatic longint blend(longint s, longint a, longint b);
    return a + ((s * (b - a)) >>> FW);
  endfunction

  function automatic int hashed(int i);
    return perm_mem[i & (DEPTH - 1)];
  endfunction

  function automatic longint dot_2d(int h, longint rx, longint ry);
    int e;
    e = h & (DEPTH - 1);
    return (rx * grad2_mem[e][0] + ry * grad2_mem[e][1]) >>> GF;
  endfunction

  function automatic longint dot_3d(int h, longint rx, longint ry, longint rz);
    int e;
    e = h & (DEPTH - 1);
    return (rx * grad3_mem[e][0] + ry * grad3_mem[e][1] + rz * grad3_mem[e][2])
      >>> GF;
  endfunction

  // Noise value for one evaluate beat, saturated to the output range.
  function automatic logic [OW-1:0] noise_predict(beat_t b);
    int bx0, bx1, by0, by1, bz0, bz1, i, j, h00, h10, h01, h11;
    longint rx0, rx1, ry0, ry1, rz0, rz1, sx, sy, sz, a, c, d, q;
    q = 0;
    bx0 = int'(b.x[23:16]);
    bx1 = (bx0 + 1) & 255;
    rx0 = longint'(b.x[15:0]);
    rx1 = rx0 - 65536;
    sx = fade(rx0);
    by0 = int'(b.y[23:16]);
    by1 = (by0 + 1) & 255;
    ry0 = longint'(b.y[15:0]);
    ry1 = ry0 - 65536;
    sy = fade(ry0);
    bz0 = int'(b.z[23:16]);
    bz1 = (bz0 + 1) & 255;
    rz0 = longint'(b.z[15:0]);
    rz1 = rz0 - 65536;
    sz = fade(rz0);
    i = hashed(bx0);
    j = hashed(bx1);
    h00 = hashed(i + by0);
    h10 = hashed(j + by0);
    h01 = hashed(i + by1);
    h11 = hashed(j + by1);
    case (b.dims)
      gnl_pkg::DIMS_1: begin
        q = blend(sx, (rx0 * grad1_mem[hashed(bx0)]) >>> GF,
                  (rx1 * grad1_mem[hashed(bx1)]) >>> GF);
      end
      gnl_pkg::DIMS_2: begin
        a = blend(sx, dot_2d(h00, rx0, ry0), dot_2d(h10, rx1, ry0));
        c = blend(sx, dot_2d(h01, rx0, ry1), dot_2d(h11, rx1, ry1));
        q = blend(sy, a, c);
      end
      gnl_pkg::DIMS_3: begin
        a = blend(sx, dot_3d(h00 + bz0, rx0, ry0, rz0), dot_3d(h10 + bz0, rx1, ry0, rz0));
        c = blend(sx, dot_3d(h01 + bz0, rx0, ry1, rz0), dot_3d(h11 + bz0, rx1, ry1, rz0));
        d = blend(sy, a, c);
        a = blend(sx, dot_3d(h00 + bz1, rx0, ry0, rz1), dot_3d(h10 + bz1, rx1, ry0, rz1));
        c = blend(sx, dot_3d(h01 + bz1, rx0, ry1, rz1), dot_3d(h11 + bz1, rx1, ry1, rz1));
        q = blend(sz, d, blend(sy, a, c));
      end
      default: q = 0;
    endcase
    if (q > 262143) q = 262143;
    if (q < -262144) q = -262144;
    return q[OW-1:0];
  endfunction

  // Applies a load beat to the shadow tables.
  function automatic void table_write(beat_t b);
    case (b.cmd)
      gnl_pkg::CMD_LOAD_PERM: begin
        perm_mem[b.idx] = int'(b.perm);
        grad1_mem[b.idx] = int'(b.ga);
      end
      gnl_pkg::CMD_LOAD_G3: begin
        grad3_mem[b.idx][0] = int'(b.ga);
        grad3_mem[b.idx][1] = int'(b.gb);
        grad3_mem[b.idx][2] = int'(b.gc);
      end
      gnl_pkg::CMD_LOAD_G2: begin
        grad2_mem[b.idx][0] = int'(b.ga);
        grad2_mem[b.idx][1] = int'(b.gb);
      end
      default: ;
    endcase
  endfunction

  function automatic beat_t random_beat(gnl_pkg::cmd_e c);
    beat_t b;
    bit [31:0] r;
    b.cmd = c;
    r = $urandom_range(3, 0);
    b.dims = r[1:0];
    r = $urandom;
    b.x = r[XW-1:0];
    r = $urandom;
    b.y = r[XW-1:0];
    r = $urandom;
    b.z = r[XW-1:0];
    r = $urandom;
    b.idx = r[EW-1:0];
    r = $urandom;
    b.perm = r[EW-1:0];
    r = $urandom;
    b.ga = r[GW-1:0];
    r = $urandom;
    b.gb = r[GW-1:0];
    r = $urandom;
    b.gc = r[GW-1:0];
    return b;
  endfunction

  // Offers one beat and returns at the edge where it is accepted.
  task automatic send_beat(beat_t b, bit typed, logic [OW-1:0] value);
    bit taken;
    int gap;
    gap = ($urandom_range(99, 0) < send_gap_pct) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= b.cmd;
    dims_i <= b.dims;
    coord_x_i <= b.x;
    coord_y_i <= b.y;
    coord_z_i <= b.z;
    entry_index_i <= b.idx;
    perm_value_i <= b.perm;
    grad_a_i <= b.ga;
    grad_b_i <= b.gb;
    grad_c_i <= b.gc;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    if (b.cmd == gnl_pkg::CMD_EVAL) begin
      noise_expected.push_back(typed ? value : noise_predict(b));
    end else begin
      table_write(b);
    end
  endtask

  function automatic void add_row(beat_t b, bit typed, logic [OW-1:0] value);
    row_t r;
    r.b = b;
    r.typed = typed;
    r.value = value;
    directed_rows.push_back(r);
  endfunction

  // Receiver: random stalls, or one long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_count > 0) begin
      out_stall_i <= 1'b1;
      hold_count <= hold_count - 1;
    end else if (hold_request) begin
      out_stall_i <= 1'b1;
      hold_count <= LONG_HOLD;
      hold_request = 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Result check; the beat is taken at the following rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_expected.size() == 0) begin
        failures++;
        if (mismatches++ < 10) $display("unexpected result beat: %0d", noise_value_o);
      end else if (noise_value_o !== noise_expected[0]) begin
        failures++;
        if (mismatches++ < 10) begin
          $display("noise_value mismatch: expected %0d, got %0d",
                   $signed(noise_expected[0]), noise_value_o);
        end
        void'(noise_expected.pop_front());
      end else begin
        void'(noise_expected.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    beat_t b;
    gnl_pkg::cmd_e load_cmd;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every entry of every table; the end entries get extreme values.
    send_gap_pct = 15;
    stall_pct = 67;
    for (int t = 0; t < 3; t++) begin
      load_cmd = (t == 0) ? gnl_pkg::CMD_LOAD_PERM :
                 (t == 1) ? gnl_pkg::CMD_LOAD_G2 : gnl_pkg::CMD_LOAD_G3;
      for (int e = 0; e < DEPTH; e++) begin
        b = random_beat(load_cmd);
        b.idx = e[EW-1:0];
        if (e == 0) begin
          b.ga = GRAD_MIN; b.gb = GRAD_MIN; b.gc = GRAD_MIN; b.perm = 8'hff;
        end else if (e == 255) begin
          b.ga = GRAD_MAX; b.gb = GRAD_MAX; b.gc = GRAD_MAX; b.perm = 8'h00;
        end
        send_beat(b, 1'b0, '0);
      end
    end

    // Directed table: dimension zero, whole-number coordinates, extremes, table rewrites, mid-cell points.
    b = random_beat(gnl_pkg::CMD_EVAL);
    b.dims = 2'd0; b.x = 29'h0fffffff; b.y = 29'h10000000; b.z = '1;
    add_row(b, 1'b1, '0);
    b.dims = gnl_pkg::DIMS_1; b.x = 29'h00050000;
    add_row(b, 1'b1, '0);
    b.dims = gnl_pkg::DIMS_2; b.x = 29'h10000000; b.y = 29'h00ff0000;
    add_row(b, 1'b1, '0);
    b.dims = gnl_pkg::DIMS_3; b.x = '0; b.y = 29'h0fff0000; b.z = 29'h10010000;
    add_row(b, 1'b1, '0);
    for (int d = 1; d <= 3; d++) begin
      b.dims = d[1:0];
      b.x = 29'h0fffffff; b.y = 29'h0fffffff; b.z = 29'h0fffffff;
      add_row(b, 1'b0, '0);
      b.x = 29'h10000000; b.y = 29'h10000000; b.z = 29'h10000000;
      add_row(b, 1'b0, '0);
      b.x = 29'h1fffffff; b.y = 29'h0000ffff; b.z = 29'h00ff8000;
      add_row(b, 1'b0, '0);
    end
    b = random_beat(gnl_pkg::CMD_LOAD_PERM); b.idx = 8'hff; b.perm = 8'hff;
    b.ga = GRAD_MAX;
    add_row(b, 1'b0, '0);
    b = random_beat(gnl_pkg::CMD_LOAD_G2); b.idx = 8'h00; b.ga = GRAD_MIN;
    b.gb = GRAD_MAX;
    add_row(b, 1'b0, '0);
    b = random_beat(gnl_pkg::CMD_LOAD_G3); b.idx = 8'h80; b.ga = GRAD_MAX;
    b.gb = GRAD_MIN; b.gc = GRAD_MAX;
    add_row(b, 1'b0, '0);
    for (int d = 1; d <= 3; d++) begin
      b = random_beat(gnl_pkg::CMD_EVAL);
      b.dims = d[1:0];
      b.x = 29'h00ff8000; b.y = 29'h00ff8000; b.z = 29'h007f8000;
      add_row(b, 1'b0, '0);
    end
    foreach (directed_rows[k]) begin
      send_beat(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].value);
    end

    // Random beats in three back-pressure phases.
    for (int phase = 0; phase < 3; phase++) begin
      in_valid_i <= 1'b0;
      wait (noise_expected.size() == 0);
      @(posedge clk_i);
      send_gap_pct = (phase == 0) ? 15 : (phase == 1) ? 67 : 0;
      stall_pct = (phase == 0) ? 67 : (phase == 1) ? 15 : 0;
      if (phase == 2) hold_request = 1'b1;
      for (int n = 0; n < RANDOM_BEATS / 3; n++) begin
        if ($urandom_range(99, 0) < 80) begin
          b = random_beat(gnl_pkg::CMD_EVAL);
        end else begin
          load_cmd = gnl_pkg::cmd_e'($urandom_range(3, 1));
          b = random_beat(load_cmd);
        end
        send_beat(b, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    wait (noise_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && noise_expected.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
